FILE: rtl/multi_slot_tick_scheduler_unit_macros.svh
// Assertion macros for the multi-slot tick scheduler.
`ifndef MULTI_SLOT_TICK_SCHEDULER_UNIT_MACROS_SVH
`define MULTI_SLOT_TICK_SCHEDULER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MSTS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define MSTS_ASSERT_ONEHOT0(lbl, vec, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(vec)) else $error(msg);
`else
`define MSTS_ASSERT(lbl, prop, msg)
`define MSTS_ASSERT_ONEHOT0(lbl, vec, msg)
`endif
`endif

FILE: rtl/msts_pkg.sv
// Shared codes and types for the multi-slot tick scheduler.
package msts_pkg;

	localparam logic [2:0] KIND_TICK   = 3'd0;
	localparam logic [2:0] KIND_REG    = 3'd1;
	localparam logic [2:0] KIND_START  = 3'd2;
	localparam logic [2:0] KIND_CANCEL = 3'd3;
	localparam logic [2:0] KIND_CLEAR  = 3'd4;

	localparam logic [1:0] EV_ASSIGNED = 2'd0;
	localparam logic [1:0] EV_FULL     = 2'd1;
	localparam logic [1:0] EV_EXPIRED  = 2'd2;
	localparam logic [1:0] EV_DONE     = 2'd3;

	localparam int PERIOD_BITS = 32;

	// walk context broadcast to every cell
	typedef struct packed {
		logic                   is_reg;
		logic [PERIOD_BITS-1:0] period;
		logic                   rep;
	} walk_t;

	// addressed slot commands, decoded per cell
	typedef struct packed {
		logic set_run;
		logic clr_run;
		logic empty;
	} cmd_t;

endpackage

FILE: rtl/msts_cell.sv
// One timer slot of the scheduler chain; holds its state and passes the walk token on.
module msts_cell #(
	parameter int COUNT_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           tok_in,
	input  msts_pkg::walk_t walk,
	input  msts_pkg::cmd_t  cmd,
	output logic           tok_out,
	output logic           hit
);
	import msts_pkg::*;

	localparam int CMP_W = (COUNT_BITS > PERIOD_BITS) ? COUNT_BITS : PERIOD_BITS;

	logic                   tok_q;
	logic                   occ_q;
	logic                   run_q;
	logic [COUNT_BITS-1:0]  elapsed_q;
	logic [PERIOD_BITS-1:0] period_q;
	logic                   rep_q;

	logic [COUNT_BITS-1:0]  nxt;
	logic                   active_tick;
	logic                   expire;
	logic                   claim;

	// saturating increment
	assign nxt         = (&elapsed_q) ? elapsed_q : elapsed_q + COUNT_BITS'(1);
	assign active_tick = tok_q & ~walk.is_reg & occ_q & run_q;
	assign expire      = active_tick & (CMP_W'(nxt) >= CMP_W'(period_q));
	assign claim       = tok_q & walk.is_reg & ~occ_q;
	assign hit         = expire | claim;
	assign tok_out     = tok_q & ~claim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q     <= 1'b0;
			occ_q     <= 1'b0;
			run_q     <= 1'b0;
			elapsed_q <= '0;
		end else begin
			tok_q <= tok_in;
			if (cmd.empty) begin
				occ_q     <= 1'b0;
				run_q     <= 1'b0;
				elapsed_q <= '0;
			end else if (cmd.set_run) begin
				run_q <= 1'b1;
			end else if (cmd.clr_run) begin
				run_q <= 1'b0;
			end
			if (claim) begin
				occ_q     <= 1'b1;
				elapsed_q <= '0;
			end
			if (active_tick) begin
				if (expire && rep_q) begin
					elapsed_q <= '0;
				end else begin
					elapsed_q <= nxt;
				end
				if (expire && !rep_q) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// period and mode are only read once the slot is occupied
	always_ff @(posedge clk) begin
		if (claim) begin
			period_q <= walk.period;
			rep_q    <= walk.rep;
		end
	end

endmodule

FILE: rtl/multi_slot_tick_scheduler_unit.sv
// Top level of the multi-slot tick scheduler: a chain of timer slot cells and its result port.
// Start, cancel, clear and unknown commands: one result, in the cycle after the transaction.
// Register: a token walks the cells one per cycle; the lowest free slot claims it and its result is
// registered from that claim, or from the token falling off the last cell when the table is full.
// Tick: the token visits every slot, one per cycle; expiries stream out in slot order and the
// closing result follows once the token has left the last cell. busy stays high throughout a walk.
// arst_n clears all slots, the token chain and the result strobe; the receiver cannot stall.
`include "multi_slot_tick_scheduler_unit_macros.svh"

module multi_slot_tick_scheduler_unit #(
	parameter int SLOTS      = 8,
	parameter int COUNT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic [2:0]  slot,
	input  logic [31:0] period,
	input  logic        repeat_req,
	output logic        strobe,
	output logic [1:0]  event_res,
	output logic [2:0]  which_slot,
	output logic        last
);
	import msts_pkg::*;

	logic             busy_q;
	logic             end_q;
	walk_t            walk_q;
	logic             strobe_q;
	logic [1:0]       event_q;
	logic [2:0]       which_q;
	logic             last_q;

	logic             accept;
	logic             is_walk;
	logic             direct;
	logic             inject;
	logic [SLOTS-1:0] tok_in;
	logic [SLOTS-1:0] tok_out;
	logic [SLOTS-1:0] hit;
	cmd_t             cmd [SLOTS];
	logic             any_hit;
	logic [2:0]       hit_idx;

	// a transaction is taken only while no walk is in flight
	assign accept  = start & ~busy_q;
	assign is_walk = (kind == KIND_TICK) || (kind == KIND_REG);
	assign direct  = accept & ~is_walk;
	assign inject  = accept & is_walk;

	// token enters slot 0 on acceptance and ripples one cell per cycle
	genvar gi;
	generate
		for (gi = 0; gi < SLOTS; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				assign tok_in[gi] = inject;
			end else begin : g_link
				assign tok_in[gi] = tok_out[gi-1];
			end

			// slot field is three bits wide; cells beyond eight are never addressed
			always_comb begin
				cmd[gi].set_run = direct && (kind == KIND_START)  && (32'(slot) == gi);
				cmd[gi].clr_run = direct && (kind == KIND_CANCEL) && (32'(slot) == gi);
				cmd[gi].empty   = direct && (kind == KIND_CLEAR)  && (32'(slot) == gi);
			end

			msts_cell #(
				.COUNT_BITS(COUNT_BITS)
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.tok_in (tok_in[gi]),
				.walk   (walk_q),
				.cmd    (cmd[gi]),
				.tok_out(tok_out[gi]),
				.hit    (hit[gi])
			);
		end
	endgenerate

	// only the cell holding the token can hit, so an OR of indices encodes it
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (hit[i]) begin
				hit_idx = hit_idx | 3'(i);
			end
		end
	end
	assign any_hit = |hit;

	// control: busy spans a walk; end_q marks the token falling off the last cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			end_q    <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			end_q    <= tok_out[SLOTS-1];
			strobe_q <= direct | any_hit | end_q;
			if (inject) begin
				busy_q <= 1'b1;
			end else if (end_q || (walk_q.is_reg && any_hit)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// walk context and result payload
	always_ff @(posedge clk) begin
		if (inject) begin
			walk_q.is_reg <= (kind == KIND_REG);
			walk_q.period <= period;
			walk_q.rep    <= repeat_req;
		end
		if (direct) begin
			event_q <= EV_DONE;
			which_q <= '0;
			last_q  <= 1'b1;
		end else if (any_hit) begin
			event_q <= walk_q.is_reg ? EV_ASSIGNED : EV_EXPIRED;
			which_q <= hit_idx;
			last_q  <= walk_q.is_reg;
		end else if (end_q) begin
			event_q <= walk_q.is_reg ? EV_FULL : EV_DONE;
			which_q <= '0;
			last_q  <= 1'b1;
		end
	end

	assign busy       = busy_q;
	assign strobe     = strobe_q;
	assign event_res  = event_q;
	assign which_slot = which_q;
	assign last       = last_q;

	`MSTS_ASSERT_ONEHOT0(a_tok_single, tok_out, "more than one cell holds the walk token")
	`MSTS_ASSERT_ONEHOT0(a_hit_single, hit, "more than one cell reports a hit")
	`MSTS_ASSERT(a_tok_busy, (|tok_out) |-> busy_q, "walk token present while not busy")
	`MSTS_ASSERT(a_end_quiet, end_q |-> !any_hit, "closing result collides with a slot hit")

endmodule
